// ===== hw/rtl/crem_pkg.sv =====
// ----------------------------------------------------------------------------
// crem_pkg
// Shared types and constants for the color region edge marker: item
// layouts, geometry limits and register map.
// ----------------------------------------------------------------------------
package crem_pkg;

   // Geometry limits and field widths
   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;
   localparam int MIN_DIM    = 3;
   localparam int PIX_W      = 8;
   localparam int COORD_W    = 9;
   localparam int DIM_W      = 10;

   // Line store
   localparam int LINE_DEPTH = MAX_WIDTH;
   localparam int LINE_AW    = $clog2(LINE_DEPTH);

   // Register port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      REG_TARGET_COLOR = 2'd0,
      REG_FRAME_WIDTH  = 2'd1,
      REG_FRAME_HEIGHT = 2'd2
   } reg_index_type;

   // Input item: one pixel in raster order
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } req_type;

   // Result item: one judged interior pixel
   typedef struct packed {
      logic [COORD_W-1:0] center_x;
      logic [COORD_W-1:0] center_y;
      logic               is_edge;
   } rsp_type;

endpackage

// ===== hw/rtl/color_region_edge_marker.sv =====
// ----------------------------------------------------------------------------
// color_region_edge_marker
// Marks the boundary of a target-color region in an indexed-color raster
// stream, judging each interior pixel against its four direct neighbors.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  crem_pkg::req_type
//   rsp_      out        rsp_valid / rsp_stall  crem_pkg::rsp_type
//   csr_      in / out   APB write at access    target_color, frame_width,
//                                               frame_height
//
// One item per cycle sustained unless rsp_stall or the clearing pass holds it;
// a judged item passes stage 1 (line store read), then the output register.
// The two line stores share one 512 x 16 memory, read and written once per
// item; a same-column access by consecutive items is forwarded.
// After reset a clearing pass zeroes all 512 memory entries, req_stall high.
// A stalled result holds stage 1; with stage 1 full, req_stall follows it.
// ----------------------------------------------------------------------------
module color_region_edge_marker (
   input  logic                                clock,
   input  logic                                reset,
   // input items
   input  logic                                req_valid,
   output logic                                req_stall,
   input  crem_pkg::req_type                   req_data,
   // result items
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output crem_pkg::rsp_type                   rsp_data,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [crem_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [crem_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [crem_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int PW = crem_pkg::PIX_W;
   localparam int CW = crem_pkg::COORD_W;
   localparam int DW = crem_pkg::DIM_W;
   localparam int AW = crem_pkg::LINE_AW;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [PW-1:0] target_color_ff;
   logic [DW-1:0] frame_width_ff;
   logic [DW-1:0] frame_height_ff;
   logic          csr_write;
   crem_pkg::reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = crem_pkg::reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_color_ff <= '0;
         frame_width_ff  <= DW'(320);
         frame_height_ff <= DW'(200);
      end else if (csr_write) begin
         case (csr_index)
            crem_pkg::REG_TARGET_COLOR: target_color_ff <= csr_pwdata[PW-1:0];
            crem_pkg::REG_FRAME_WIDTH:  frame_width_ff  <= csr_pwdata[DW-1:0];
            crem_pkg::REG_FRAME_HEIGHT: frame_height_ff <= csr_pwdata[DW-1:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (csr_index)
         crem_pkg::REG_TARGET_COLOR:
            csr_prdata = {{(crem_pkg::CSR_DATA_W-PW){1'b0}}, target_color_ff};
         crem_pkg::REG_FRAME_WIDTH:
            csr_prdata = {{(crem_pkg::CSR_DATA_W-DW){1'b0}}, frame_width_ff};
         crem_pkg::REG_FRAME_HEIGHT:
            csr_prdata = {{(crem_pkg::CSR_DATA_W-DW){1'b0}}, frame_height_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   // clamp geometry to the supported range
   logic [DW-1:0] width_eff;
   logic [DW-1:0] height_eff;

   always_comb begin
      if (frame_width_ff < DW'(crem_pkg::MIN_DIM))
         width_eff = DW'(crem_pkg::MIN_DIM);
      else if (frame_width_ff > DW'(crem_pkg::MAX_WIDTH))
         width_eff = DW'(crem_pkg::MAX_WIDTH);
      else
         width_eff = frame_width_ff;

      if (frame_height_ff < DW'(crem_pkg::MIN_DIM))
         height_eff = DW'(crem_pkg::MIN_DIM);
      else if (frame_height_ff > DW'(crem_pkg::MAX_HEIGHT))
         height_eff = DW'(crem_pkg::MAX_HEIGHT);
      else
         height_eff = frame_height_ff;
   end

   // ---------------------------------------------------------------------
   // Handshake control
   // ---------------------------------------------------------------------
   logic          clear_active_ff;
   logic [AW-1:0] clear_addr_ff;
   logic          s1_valid_ff;
   logic          s1_adv;
   logic          req_accept;
   logic          rsp_valid_ff;
   crem_pkg::rsp_type rsp_data_ff;

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = clear_active_ff || (s1_valid_ff && !s1_adv);
   assign req_accept = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // Stage 0: position of the incoming pixel
   // ---------------------------------------------------------------------
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] col_start;
   logic [DW-1:0] row_start;
   logic [CW-1:0] x0, y0;
   logic [DW-1:0] x_inc, y_inc;

   always_comb begin
      col_start = req_data.frame_start ? '0 : col_ff;
      row_start = req_data.frame_start ? '0 : {1'b0, row_ff};
      // column out of range after a width change starts the next row
      if ({1'b0, col_start} >= width_eff) begin
         col_start = '0;
         row_start = row_start + DW'(1);
      end
      if (row_start >= height_eff)
         row_start = '0;
      x0 = col_start;
      y0 = row_start[CW-1:0];

      // advance for the following pixel
      x_inc = {1'b0, x0} + DW'(1);
      y_inc = {1'b0, y0} + DW'(1);
      if (x_inc >= width_eff) begin
         col_in = '0;
         row_in = (y_inc >= height_eff) ? '0 : y_inc[CW-1:0];
      end else begin
         col_in = x_inc[CW-1:0];
         row_in = y0;
      end
   end

   // ---------------------------------------------------------------------
   // Line store: {older, prev} per column, one read and one write a cycle
   // ---------------------------------------------------------------------
   logic [2*PW-1:0] line_mem [crem_pkg::LINE_DEPTH];
   logic [2*PW-1:0] rd_data_ff;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [2*PW-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en)
         line_mem[wr_addr] <= wr_data;
      if (req_accept)
         rd_data_ff <= line_mem[x0[AW-1:0]];
   end

   // ---------------------------------------------------------------------
   // Stage 1: window, edge test and write-back
   // ---------------------------------------------------------------------
   logic [PW-1:0] s1_pixel_ff;
   logic [CW-1:0] s1_x_ff, s1_y_ff;
   logic          s1_fwd_ff;
   logic [PW-1:0] s1_fwd_prev_ff, s1_fwd_older_ff;
   logic [PW-1:0] s1_r, s1_o;
   logic          fwd_in;
   logic [PW-1:0] win_left_ff, win_mid_ff;
   logic [PW-1:0] above_hold_ff, last_pixel_ff;
   logic          s1_has_result;
   logic          s1_edge;

   // same column written by the item leaving stage 1 this cycle
   assign fwd_in = s1_adv && (s1_x_ff == x0);

   assign s1_r = s1_fwd_ff ? s1_fwd_prev_ff  : rd_data_ff[PW-1:0];
   assign s1_o = s1_fwd_ff ? s1_fwd_older_ff : rd_data_ff[2*PW-1:PW];

   assign s1_has_result = (s1_x_ff >= CW'(2)) && (s1_y_ff >= CW'(2));
   assign s1_edge = (win_mid_ff == target_color_ff) &&
                    ((win_left_ff   != target_color_ff) ||
                     (s1_r          != target_color_ff) ||
                     (above_hold_ff != target_color_ff) ||
                     (last_pixel_ff != target_color_ff));

   // memory write port: clearing pass or stage-1 write-back
   assign wr_en   = clear_active_ff || s1_adv;
   assign wr_addr = clear_active_ff ? clear_addr_ff : s1_x_ff[AW-1:0];
   assign wr_data = clear_active_ff ? '0 : {s1_r, s1_pixel_ff};

   // stage-1 payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff     <= req_data.pixel;
         s1_x_ff         <= x0;
         s1_y_ff         <= y0;
         s1_fwd_ff       <= fwd_in;
         s1_fwd_prev_ff  <= s1_pixel_ff;
         s1_fwd_older_ff <= s1_r;
      end
      if (s1_adv) begin
         rsp_data_ff.center_x <= s1_x_ff - CW'(1);
         rsp_data_ff.center_y <= s1_y_ff - CW'(1);
         rsp_data_ff.is_edge  <= s1_edge;
      end
   end

   // control and neighbor state
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff <= 1'b1;
         clear_addr_ff   <= '0;
         col_ff          <= '0;
         row_ff          <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         win_left_ff     <= '0;
         win_mid_ff      <= '0;
         above_hold_ff   <= '0;
         last_pixel_ff   <= '0;
      end else begin
         // clearing pass over the line store
         if (clear_active_ff) begin
            clear_addr_ff <= clear_addr_ff + AW'(1);
            if (clear_addr_ff == AW'(crem_pkg::LINE_DEPTH - 1))
               clear_active_ff <= 1'b0;
         end

         if (req_accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end

         if (req_accept)
            s1_valid_ff <= 1'b1;
         else if (s1_adv)
            s1_valid_ff <= 1'b0;

         if (s1_adv) begin
            win_left_ff   <= win_mid_ff;
            win_mid_ff    <= s1_r;
            above_hold_ff <= s1_o;
            last_pixel_ff <= s1_pixel_ff;
         end

         // output register
         if (s1_adv)
            rsp_valid_ff <= s1_has_result;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // clearing pass ends only after the last entry
   a_clear_len: assert property (@(posedge clock) disable iff (reset)
      $fell(clear_active_ff) |-> $past(clear_addr_ff) == AW'(crem_pkg::LINE_DEPTH - 1))
      else $error("line store clearing pass ended early");

   // a judged pixel leaving stage 1 lands in the output register
   a_result_out: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_has_result) |=> rsp_valid_ff)
      else $error("result lost between stage 1 and output");

   // only interior coordinates are reported
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.center_x != '0) && (rsp_data_ff.center_y != '0) &&
                       (rsp_data_ff.center_x < CW'(crem_pkg::MAX_WIDTH - 1)) &&
                       (rsp_data_ff.center_y < CW'(crem_pkg::MAX_HEIGHT - 1)))
      else $error("result coordinate outside interior");

   // stage 1 never waits while the output register is free
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_valid_ff) |-> s1_adv)
      else $error("stage 1 held with empty output");
`endif

endmodule

// ===== dv/color_region_edge_marker_test.sv =====
// ----------------------------------------------------------------------------
// color_region_edge_marker_test
// Self-checking bench for the region boundary marker. Streams indexed-color
// pixels through the input channel and keeps a cycle-free prediction of each
// judged interior pixel (coordinates and edge flag) from its own copy of the
// line stores, window and position counters. Covers reset geometry, clamped
// and oversized frame sizes, mid-frame restarts and geometry changes, long
// output hold-off and random traffic with random idling on both sides.
// ----------------------------------------------------------------------------
module color_region_edge_marker_test;

   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 4000;
   localparam int HOLD_OFF      = 300;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   crem_pkg::req_type               req_data;
   logic                            rsp_valid;
   logic                            rsp_stall;
   crem_pkg::rsp_type               rsp_data;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [crem_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [crem_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [crem_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   color_region_edge_marker DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predicted line stores, middle-row window and position
   logic [crem_pkg::PIX_W-1:0] above_line [crem_pkg::LINE_DEPTH];
   logic [crem_pkg::PIX_W-1:0] older_line [crem_pkg::LINE_DEPTH];
   logic [crem_pkg::PIX_W-1:0] mid_window [3];
   logic [crem_pkg::PIX_W-1:0] hold_above;
   logic [crem_pkg::PIX_W-1:0] prev_pixel;
   int                         next_col;
   int                         next_row;

   // Predicted register contents
   logic [crem_pkg::PIX_W-1:0] target_reg;
   logic [crem_pkg::DIM_W-1:0] width_reg;
   logic [crem_pkg::DIM_W-1:0] height_reg;

   crem_pkg::rsp_type pending_marks [$];
   crem_pkg::rsp_type want_mark;

   int mismatch_count;
   int pixels_sent;
   int marks_checked;
   int edges_seen;
   int idle_cycles;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_cycles;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH @%0t: %s", $realtime, what);
   endtask

   function automatic int clamp_dim(input logic [crem_pkg::DIM_W-1:0] v, input int hi);
      if (v < crem_pkg::MIN_DIM) return crem_pkg::MIN_DIM;
      if (v > hi) return hi;
      return int'(v);
   endfunction

   // Advance the predicted block by one pixel; queue a mark if one is judged
   task automatic predict_pixel(input crem_pkg::req_type item);
      int                         w;
      int                         h;
      int                         x;
      int                         y;
      logic [crem_pkg::PIX_W-1:0] upper;
      logic [crem_pkg::PIX_W-1:0] older;
      crem_pkg::rsp_type          mark;
      w = clamp_dim(width_reg, crem_pkg::MAX_WIDTH);
      h = clamp_dim(height_reg, crem_pkg::MAX_HEIGHT);
      if (item.frame_start) begin
         next_col = 0;
         next_row = 0;
      end
      // position may lie outside a geometry that shrank mid-frame
      if (next_col >= w) begin
         next_col = 0;
         next_row++;
      end
      if (next_row >= h) next_row = 0;
      x = next_col;
      y = next_row;
      upper = above_line[x];
      older = older_line[x];
      mid_window[0] = mid_window[1];
      mid_window[1] = mid_window[2];
      mid_window[2] = upper;
      if (x >= 2 && y >= 2) begin
         mark.center_x = crem_pkg::COORD_W'(x - 1);
         mark.center_y = crem_pkg::COORD_W'(y - 1);
         mark.is_edge  = (mid_window[1] == target_reg) &&
                         (mid_window[0] != target_reg || mid_window[2] != target_reg ||
                          hold_above != target_reg || prev_pixel != target_reg);
         pending_marks.push_back(mark);
      end
      older_line[x] = upper;
      above_line[x] = item.pixel;
      hold_above    = older;
      prev_pixel    = item.pixel;
      next_col = x + 1;
      if (next_col >= w) begin
         next_col = 0;
         next_row = y + 1;
         if (next_row >= h) next_row = 0;
      end
   endtask

   // Offer one pixel, with random idle cycles in front, until accepted
   task automatic send_pixel(input logic [crem_pkg::PIX_W-1:0] px, input logic fs);
      crem_pkg::req_type item;
      item.pixel       = px;
      item.frame_start = fs;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_pixel(item);
      pixels_sent++;
   endtask

   // Stop offering, wait for every expected mark, then let the pipe settle
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_marks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One APB transfer: setup cycle, then access until pready
   task automatic csr_access(input crem_pkg::reg_index_type idx, input logic wr,
                             input logic [crem_pkg::CSR_DATA_W-1:0] wdata,
                             output logic [crem_pkg::CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = wr;
      csr_paddr   = crem_pkg::CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic check_reg(input crem_pkg::reg_index_type idx);
      logic [crem_pkg::CSR_DATA_W-1:0] got;
      logic [crem_pkg::CSR_DATA_W-1:0] want;
      csr_access(idx, 1'b0, '0, got);
      case (idx)
         crem_pkg::REG_TARGET_COLOR: want = crem_pkg::CSR_DATA_W'(target_reg);
         crem_pkg::REG_FRAME_WIDTH:  want = crem_pkg::CSR_DATA_W'(width_reg);
         default:                    want = crem_pkg::CSR_DATA_W'(height_reg);
      endcase
      if (got !== want) begin
         report_mismatch($sformatf("register %s read %0h, want %0h", idx.name(), got, want));
      end
   endtask

   // Registers change only with the block idle
   task automatic set_reg(input crem_pkg::reg_index_type idx,
                          input logic [crem_pkg::CSR_DATA_W-1:0] value);
      logic [crem_pkg::CSR_DATA_W-1:0] unused;
      drain_results();
      csr_access(idx, 1'b1, value, unused);
      case (idx)
         crem_pkg::REG_TARGET_COLOR: target_reg = value[crem_pkg::PIX_W-1:0];
         crem_pkg::REG_FRAME_WIDTH:  width_reg  = value[crem_pkg::DIM_W-1:0];
         default:                    height_reg = value[crem_pkg::DIM_W-1:0];
      endcase
      check_reg(idx);
   endtask

   // Pixels biased toward the target color so regions and boundaries form;
   // noise injects mid-frame restarts or cuts the frame short
   task automatic stream_pixels(input int count, input logic fs_first, input int noise_pct);
      logic [crem_pkg::PIX_W-1:0] alt;
      logic [crem_pkg::PIX_W-1:0] px;
      int                         n;
      alt = crem_pkg::PIX_W'($urandom_range(255));
      for (n = 0; n < count; n++) begin
         case ($urandom_range(9))
            0:       px = crem_pkg::PIX_W'($urandom_range(255));
            1, 2, 3: px = alt;
            default: px = target_reg;
         endcase
         if (n == 0) begin
            send_pixel(px, fs_first);
         end else if ($urandom_range(99) < noise_pct) begin
            if ($urandom_range(1) == 1) send_pixel(px, 1'b1);
            else break;
         end else begin
            send_pixel(px, 1'b0);
         end
      end
   endtask

   task automatic test_register_reset();
      check_reg(crem_pkg::REG_TARGET_COLOR);
      check_reg(crem_pkg::REG_FRAME_WIDTH);
      check_reg(crem_pkg::REG_FRAME_HEIGHT);
   endtask

   // Reset geometry and reset counters, no frame start: row 0 gives no marks
   task automatic test_reset_geometry();
      int n;
      for (n = 0; n < 40; n++) begin
         if ($urandom_range(3) == 0) send_pixel(crem_pkg::PIX_W'($urandom_range(255)), 1'b0);
         else send_pixel('0, 1'b0);
      end
   endtask

   // Hand-built frames: quiet interior, upper/right neighbor differing,
   // non-target center, then a restart in the middle of a row
   task automatic test_directed_cases();
      byte unsigned frame_a [15];
      byte unsigned frame_b [9];
      int           n;
      frame_a = '{8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF,
                  8'hFF, 8'hFF, 8'hFF, 8'h07, 8'h00,
                  8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF};
      frame_b = '{8'h00, 8'h00, 8'h00,
                  8'h00, 8'h00, 8'hFF,
                  8'h00, 8'h00, 8'h00};
      set_reg(crem_pkg::REG_TARGET_COLOR, 32'hFF);
      set_reg(crem_pkg::REG_FRAME_WIDTH, 32'd5);
      set_reg(crem_pkg::REG_FRAME_HEIGHT, 32'd3);
      for (n = 0; n < 15; n++) send_pixel(frame_a[n], n == 0);
      set_reg(crem_pkg::REG_TARGET_COLOR, 32'h00);
      set_reg(crem_pkg::REG_FRAME_WIDTH, 32'd3);
      send_pixel(8'hFF, 1'b1);
      send_pixel(8'h00, 1'b0);
      send_pixel(8'h80, 1'b0);
      send_pixel(8'h01, 1'b0);
      for (n = 0; n < 9; n++) send_pixel(frame_b[n], n == 0);
   endtask

   // Geometry below the minimum and above the maximum
   task automatic test_geometry_clamp();
      int n;
      set_reg(crem_pkg::REG_TARGET_COLOR, 32'd9);
      for (n = 0; n < 3; n++) begin
         set_reg(crem_pkg::REG_FRAME_WIDTH, n);
         set_reg(crem_pkg::REG_FRAME_HEIGHT, 2 - n);
         stream_pixels(9, 1'b1, 0);
         stream_pixels(9, 1'b0, 0);
      end
      // oversized width: the first line is still filling, no marks yet
      set_reg(crem_pkg::REG_FRAME_WIDTH, 32'd1023);
      set_reg(crem_pkg::REG_FRAME_HEIGHT, 32'd3);
      stream_pixels(40, 1'b1, 0);
      // oversized height: a narrow frame keeps marking well past row 2
      set_reg(crem_pkg::REG_FRAME_WIDTH, 32'd3);
      set_reg(crem_pkg::REG_FRAME_HEIGHT, 32'd1023);
      stream_pixels(30, 1'b1, 0);
   endtask

   // Shrink width while past the new last column, then height past last row
   task automatic test_mid_frame_geometry();
      set_reg(crem_pkg::REG_TARGET_COLOR, $urandom_range(255));
      set_reg(crem_pkg::REG_FRAME_WIDTH, 32'd8);
      set_reg(crem_pkg::REG_FRAME_HEIGHT, 32'd6);
      stream_pixels(21, 1'b1, 0);
      set_reg(crem_pkg::REG_FRAME_WIDTH, 32'd4);
      stream_pixels(6, 1'b0, 0);
      set_reg(crem_pkg::REG_FRAME_HEIGHT, 32'd3);
      stream_pixels(16, 1'b0, 0);
   endtask

   // Long output hold-off with the sender flat out, then a full pause mid-frame
   task automatic test_backpressure();
      set_reg(crem_pkg::REG_TARGET_COLOR, $urandom_range(255));
      set_reg(crem_pkg::REG_FRAME_WIDTH, 32'd6);
      set_reg(crem_pkg::REG_FRAME_HEIGHT, 32'd5);
      send_idle_pct = 0;
      hold_cycles   = HOLD_OFF;
      stream_pixels(60, 1'b1, 0);
      stream_pixels(10, 1'b1, 0);
      drain_results();
      stream_pixels(20, 1'b0, 0);
   endtask

   task automatic random_phase(input int send_pct, input int recv_pct, input int count);
      int phase_base;
      int pick;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      phase_base     = pixels_sent;
      while (pixels_sent - phase_base < count) begin
         if ($urandom_range(2) == 0) begin
            pick = $urandom_range(5);
            if (pick == 0) set_reg(crem_pkg::REG_TARGET_COLOR, 32'h00);
            else if (pick == 1) set_reg(crem_pkg::REG_TARGET_COLOR, 32'hFF);
            else set_reg(crem_pkg::REG_TARGET_COLOR, $urandom_range(255));
            set_reg(crem_pkg::REG_FRAME_WIDTH, $urandom_range(10));
            set_reg(crem_pkg::REG_FRAME_HEIGHT, $urandom_range(7));
         end
         stream_pixels(clamp_dim(width_reg, crem_pkg::MAX_WIDTH) *
                       clamp_dim(height_reg, crem_pkg::MAX_HEIGHT),
                       $urandom_range(9) != 0, 4);
      end
   endtask

   task automatic test_random_frames();
      random_phase(13, 74, 95);
      random_phase(74, 13, 95);
      random_phase(0, 0, 95);
   endtask

   // Output side: random stall, or a counted hold-off when requested
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall = 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall = ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // Compare each accepted mark with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_marks.size() == 0) begin
            report_mismatch($sformatf("unexpected mark x=%0d y=%0d edge=%0b",
                                      rsp_data.center_x, rsp_data.center_y, rsp_data.is_edge));
         end else begin
            want_mark = pending_marks.pop_front();
            marks_checked++;
            if (rsp_data.is_edge === 1'b1) edges_seen++;
            if (rsp_data.center_x !== want_mark.center_x) begin
               report_mismatch($sformatf("center_x %0d, want %0d",
                                         rsp_data.center_x, want_mark.center_x));
            end
            if (rsp_data.center_y !== want_mark.center_y) begin
               report_mismatch($sformatf("center_y %0d, want %0d",
                                         rsp_data.center_y, want_mark.center_y));
            end
            if (rsp_data.is_edge !== want_mark.is_edge) begin
               report_mismatch($sformatf("is_edge %0b, want %0b at x=%0d y=%0d",
                                         rsp_data.is_edge, want_mark.is_edge,
                                         want_mark.center_x, want_mark.center_y));
            end
         end
      end
   end

   // Watchdog: too long without any item moving on either channel
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Test sequence
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      mismatch_count = 0;
      pixels_sent    = 0;
      marks_checked  = 0;
      edges_seen     = 0;
      hold_cycles    = 0;
      send_idle_pct  = 13;
      recv_stall_pct = 74;
      target_reg     = '0;
      width_reg      = crem_pkg::DIM_W'(320);
      height_reg     = crem_pkg::DIM_W'(200);
      hold_above     = '0;
      prev_pixel     = '0;
      next_col       = 0;
      next_row       = 0;
      foreach (above_line[i]) above_line[i] = '0;
      foreach (older_line[i]) older_line[i] = '0;
      foreach (mid_window[i]) mid_window[i] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_register_reset();
      test_reset_geometry();
      test_directed_cases();
      test_geometry_clamp();
      test_mid_frame_geometry();
      test_backpressure();
      send_idle_pct = 13;
      test_random_frames();

      drain_results();
      if (pending_marks.size() != 0) begin
         report_mismatch($sformatf("%0d marks never arrived", pending_marks.size()));
      end
      $display("%0d pixels streamed, %0d interior marks checked, %0d of them boundary",
               pixels_sent, marks_checked, edges_seen);
      $display("clamped and oversized geometry, restarts, resizes, hold-off, idling");
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
